/* sv/assert_macros.svh */
// assertion macros used by the converter datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/i2p_pkg.sv */
// package: types, constants and rank function for the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_A      = 8'h61;  // 'a'
  localparam logic [7:0] CH_Z      = 8'h7a;  // 'z'
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PCT    = 8'h25;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [7:0] sym;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_sym;
    logic [1:0] status;
    logic       run_last;
    logic       expr_end;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       rd_en;
    logic       rd_below;   // read the entry under the top
    logic       pop;
    logic       push;
    logic       put;
    logic       put_top;    // result takes the stack read data, else the held symbol
    logic [1:0] put_status;
    logic       finish;
  } i2p_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_letter;
    logic is_open;
    logic is_close;
    logic last;
    logic empty;
    logic one_left;
    logic full;
    logic top_is_open;
    logic rank_gt;
    logic put_ok;
  } i2p_stat_t;

  function automatic logic [1:0] sym_rank(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    case (c)
      CH_LPAREN, CH_RPAREN:      r = 2'd3;
      CH_PLUS, CH_MINUS:         r = 2'd1;
      CH_STAR, CH_SLASH, CH_PCT: r = 2'd2;
      default:                   r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/infix_to_postfix_converter.sv */
// top level: shunting-yard infix to postfix converter, one character per request
// an operand result passes through the pending and output registers; the next request is taken in idle
// an operator or ')' on a non-empty stack pops entries to the results until it can be pushed or dropped
// an is_last request then flushes the stack, one result per cycle unless the result channel stalls
// the sequencer stalls while the result channel holds back and the pending result slot is full
// reset: synchronous active-low rst_n empties the stack and drops pending results
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  i2p_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output i2p_pkg::out_item_t out_data
);

  import i2p_pkg::*;

  // command and status bundles between the sequencer and the datapath
  i2p_cmd_t  cmd;
  i2p_stat_t stat;

  // sequencer: classifies the held request, walks the stack one entry a cycle while results can be taken
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stack ram (contents undefined until pushed), count, one-deep
  // holding stage for the run_last flag, and the output register
  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/i2p_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/i2p_ctrl.sv */
// controller state machine for the infix to postfix converter
`timescale 1ns / 1ps

module i2p_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2p_pkg::i2p_stat_t stat,
  output i2p_pkg::i2p_cmd_t  cmd
);

  import i2p_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_CHK,
    S_END,
    S_FLUSH,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.is_letter) begin
          if (stat.put_ok) begin
            cmd.put        = 1'b1;
            cmd.put_status = ST_OK;
            state_nxt      = S_END;
          end
        end else if (stat.is_open) begin
          if (stat.full) begin
            if (stat.put_ok) begin
              cmd.put        = 1'b1;
              cmd.put_status = ST_OVERFLOW;
              state_nxt      = S_END;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_END;
          end
        end else if (stat.empty) begin
          if (stat.is_close) begin
            if (stat.put_ok) begin
              cmd.put        = 1'b1;
              cmd.put_status = ST_UNMATCHED;
              state_nxt      = S_END;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_END;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.is_close && stat.top_is_open) begin
          cmd.pop   = 1'b1;
          state_nxt = S_END;
        end else if (!stat.is_close && (stat.top_is_open || stat.rank_gt)) begin
          if (stat.full) begin
            if (stat.put_ok) begin
              cmd.put        = 1'b1;
              cmd.put_status = ST_OVERFLOW;
              state_nxt      = S_END;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_END;
          end
        end else if (stat.put_ok) begin
          cmd.put        = 1'b1;
          cmd.put_top    = 1'b1;
          cmd.put_status = ST_OK;
          cmd.pop        = 1'b1;
          if (stat.one_left) begin
            state_nxt = S_CLASS;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_below = 1'b1;
          end
        end
      end
      S_END: begin
        if (stat.last && !stat.empty) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_FLUSH;
        end else if (stat.put_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.put_ok) begin
          cmd.put        = 1'b1;
          cmd.put_top    = 1'b1;
          cmd.put_status = ST_OK;
          cmd.pop        = 1'b1;
          if (stat.one_left) begin
            state_nxt = S_FIN;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_below = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (stat.put_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/i2p_datapath.sv */
// datapath: operator stack, held request, pending result and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2p_datapath #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  i2p_pkg::in_item_t   in_data,
  input  i2p_pkg::i2p_cmd_t   cmd,
  output i2p_pkg::i2p_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output i2p_pkg::out_item_t  out_data
);

  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sym_r;
  logic          last_r;
  logic [7:0]    top_q;
  logic [CW-1:0] rd_base;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  out_item_t pend_r, pend_nxt;
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      can_emit;
  logic      put_ok;

  // read the top, or the entry under it while the top is being popped
  assign rd_base = count_r - (cmd.rd_below ? CW'(2) : CW'(1));
  assign rd_addr = rd_base[AW-1:0];
  assign wr_addr = count_r[AW-1:0];

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata (sym_r),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (top_q)
  );

  assign can_emit = !out_valid_r || out_ready;
  assign put_ok   = !pend_valid_r || can_emit;

  always_comb begin
    count_nxt = count_r;
    if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // a result is held one step so the last one of a request can be flagged
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (cmd.put) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt.out_sym  = cmd.put_top ? top_q : sym_r;
      pend_nxt.status   = cmd.put_status;
      pend_nxt.run_last = 1'b0;
      pend_nxt.expr_end = 1'b0;
      pend_valid_nxt    = 1'b1;
    end else if (cmd.finish && pend_valid_r) begin
      out_nxt          = pend_r;
      out_nxt.run_last = 1'b1;
      out_nxt.expr_end = last_r;
      out_valid_nxt    = 1'b1;
      pend_valid_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sym_r  <= in_data.sym;
      last_r <= in_data.is_last;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    stat.is_letter   = (sym_r >= CH_A) && (sym_r <= CH_Z);
    stat.is_open     = (sym_r == CH_LPAREN);
    stat.is_close    = (sym_r == CH_RPAREN);
    stat.last        = last_r;
    stat.empty       = (count_r == '0);
    stat.one_left    = (count_r == CW'(1));
    stat.full        = (count_r == CW'(STACK_DEPTH));
    stat.top_is_open = (top_q == CH_LPAREN);
    stat.rank_gt     = sym_rank(sym_r) > sym_rank(top_q);
    stat.put_ok      = put_ok;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_count_bound, count_r <= CW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_CLK(a_no_push_full, cmd.push |-> (count_r != CW'(STACK_DEPTH)), "push on full stack")
  `ASSERT_CLK(a_no_pop_empty, cmd.pop |-> (count_r != '0), "pop on empty stack")
  `ASSERT_CLK(a_put_room, (cmd.put || cmd.finish) |-> put_ok, "result issued with no room")

endmodule
